FILE: rtl/gcr_pkg.sv
// Shared constants, types, glyph table and a helper function for the glyph cell renderer.
package gcr_pkg;

  localparam int GlyphCols  = 5;
  localparam int GlyphRows  = 7;
  localparam int GlyphCount = 41;

  localparam logic [7:0] CaseFold = 8'd32;

  localparam logic [9:0] ScreenWidthRst  = 10'd240;
  localparam logic [9:0] ScreenHeightRst = 10'd320;
  localparam logic [7:0] ColOffsetRst    = 8'd0;
  localparam logic [7:0] RowOffsetRst    = 8'd0;

  typedef enum logic [1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1,
    CFG_COLUMN_OFFSET = 2'd2,
    CFG_ROW_OFFSET    = 2'd3
  } cfg_reg_t;

  typedef logic [6:0] glyph_col_t;

  localparam glyph_col_t GLYPH_ROM [GlyphCount][GlyphCols] = '{
    '{7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
    '{7'h08, 7'h08, 7'h08, 7'h08, 7'h08},
    '{7'h00, 7'h00, 7'h40, 7'h00, 7'h00},
    '{7'h00, 7'h14, 7'h00, 7'h14, 7'h00},
    '{7'h40, 7'h20, 7'h10, 7'h08, 7'h04},
    '{7'h3e, 7'h51, 7'h49, 7'h45, 7'h3e},
    '{7'h00, 7'h42, 7'h7f, 7'h40, 7'h00},
    '{7'h62, 7'h51, 7'h49, 7'h49, 7'h46},
    '{7'h22, 7'h49, 7'h49, 7'h49, 7'h36},
    '{7'h18, 7'h14, 7'h12, 7'h7f, 7'h10},
    '{7'h2f, 7'h49, 7'h49, 7'h49, 7'h31},
    '{7'h3e, 7'h49, 7'h49, 7'h49, 7'h32},
    '{7'h01, 7'h71, 7'h09, 7'h05, 7'h03},
    '{7'h36, 7'h49, 7'h49, 7'h49, 7'h36},
    '{7'h26, 7'h49, 7'h49, 7'h49, 7'h3e},
    '{7'h7e, 7'h11, 7'h11, 7'h11, 7'h7e},
    '{7'h7f, 7'h49, 7'h49, 7'h49, 7'h36},
    '{7'h3e, 7'h41, 7'h41, 7'h41, 7'h22},
    '{7'h7f, 7'h41, 7'h41, 7'h22, 7'h1c},
    '{7'h7f, 7'h49, 7'h49, 7'h49, 7'h41},
    '{7'h7f, 7'h09, 7'h09, 7'h09, 7'h01},
    '{7'h3e, 7'h41, 7'h49, 7'h49, 7'h7a},
    '{7'h7f, 7'h08, 7'h08, 7'h08, 7'h7f},
    '{7'h00, 7'h41, 7'h7f, 7'h41, 7'h00},
    '{7'h20, 7'h40, 7'h41, 7'h3f, 7'h01},
    '{7'h7f, 7'h08, 7'h14, 7'h22, 7'h41},
    '{7'h7f, 7'h40, 7'h40, 7'h40, 7'h40},
    '{7'h7f, 7'h02, 7'h0c, 7'h02, 7'h7f},
    '{7'h7f, 7'h04, 7'h08, 7'h10, 7'h7f},
    '{7'h3e, 7'h41, 7'h41, 7'h41, 7'h3e},
    '{7'h7f, 7'h09, 7'h09, 7'h09, 7'h06},
    '{7'h3e, 7'h41, 7'h51, 7'h21, 7'h5e},
    '{7'h7f, 7'h09, 7'h19, 7'h29, 7'h46},
    '{7'h46, 7'h49, 7'h49, 7'h49, 7'h31},
    '{7'h01, 7'h01, 7'h7f, 7'h01, 7'h01},
    '{7'h3f, 7'h40, 7'h40, 7'h40, 7'h3f},
    '{7'h1f, 7'h20, 7'h40, 7'h20, 7'h1f},
    '{7'h7f, 7'h20, 7'h18, 7'h20, 7'h7f},
    '{7'h63, 7'h14, 7'h08, 7'h14, 7'h63},
    '{7'h07, 7'h08, 7'h70, 7'h08, 7'h07},
    '{7'h61, 7'h51, 7'h49, 7'h45, 7'h43}
  };

  // Maps a character code to its row in the glyph table.
  function automatic logic [5:0] glyph_index(input logic [7:0] code);
    logic [7:0] c;
    logic [7:0] d;
    c = code;
    if (c >= 8'h61 && c <= 8'h7a) begin
      c = c - CaseFold;
    end
    d = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30 + 8'd5;
    end else if (c >= 8'h41 && c <= 8'h5a) begin
      d = c - 8'h41 + 8'd15;
    end else if (c == 8'h2d) begin
      d = 8'd1;
    end else if (c == 8'h2e) begin
      d = 8'd2;
    end else if (c == 8'h3a) begin
      d = 8'd3;
    end else if (c == 8'h2f) begin
      d = 8'd4;
    end
    return d[5:0];
  endfunction

endpackage

FILE: rtl/gcr_stream_if.sv
// Valid/ready channel interfaces for character requests and rectangle results.
interface gcr_in_if;
  logic               valid;
  logic               ready;
  logic        [7:0]  char_code;
  logic signed [10:0] origin_x;
  logic signed [10:0] origin_y;
  logic        [15:0] fore_color;
  logic        [15:0] back_color;
  logic        [3:0]  dot_scale;

  modport source (output valid, char_code, origin_x, origin_y, fore_color, back_color,
                  dot_scale, input ready);
  modport sink (input valid, char_code, origin_x, origin_y, fore_color, back_color,
                dot_scale, output ready);
endinterface

interface gcr_out_if;
  logic        valid;
  logic        ready;
  logic        visible;
  logic [10:0] win_x_start;
  logic [10:0] win_x_end;
  logic [10:0] win_y_start;
  logic [10:0] win_y_end;
  logic [15:0] fill_color;
  logic [7:0]  pixel_total;
  logic        last_cell;

  modport source (output valid, visible, win_x_start, win_x_end, win_y_start, win_y_end,
                  fill_color, pixel_total, last_cell, input ready);
  modport sink (input valid, visible, win_x_start, win_x_end, win_y_start, win_y_end,
                fill_color, pixel_total, last_cell, output ready);
endinterface

FILE: rtl/glyph_cell_rect_renderer_unit.sv
// Top level: splits each character into 35 clipped, scaled fill rectangles.
// Each accepted character produces 35 results, one per cycle unless the output
// stalls; they come from the cell sequencer, which walks the glyph column by
// column with the rows inside each column. The next character request is
// taken in the same cycle as the last cell of the current one leaves the
// sequencer, so characters follow each other without a gap. The first result
// of a request passes from the sequencer through two clipping stages and the
// output register. A stalled output holds the whole pipeline. Configuration
// should only be written while no character is in flight.
module glyph_cell_rect_renderer_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  gcr_in_if.sink                 in_req,
  gcr_out_if.source              out_res,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [9:0]             cfg_data
);
  import gcr_pkg::*;

  logic [9:0] screen_width_r;
  logic [9:0] screen_height_r;
  logic [7:0] column_offset_r;
  logic [7:0] row_offset_r;

  logic adv;

  // Cell sequencer.
  logic               active_r, active_nxt;
  logic        [2:0]  col_r, col_nxt;
  logic        [2:0]  row_r, row_nxt;
  logic signed [11:0] x_r, x_nxt;
  logic signed [11:0] y_r, y_nxt;
  logic signed [11:0] oy_r, oy_nxt;
  logic        [5:0]  idx_r, idx_nxt;
  logic        [15:0] fg_r, fg_nxt;
  logic        [15:0] bg_r, bg_nxt;
  logic        [3:0]  s_r, s_nxt;
  logic               seq_last;
  logic               in_fire;

  // Left and top clipping stage.
  logic               s2_valid_r, s2_valid_nxt;
  logic               s2_vis0_r, s2_vis0_nxt;
  logic        [10:0] s2_x_r, s2_x_nxt;
  logic        [10:0] s2_y_r, s2_y_nxt;
  logic signed [11:0] s2_w_r, s2_w_nxt;
  logic signed [11:0] s2_h_r, s2_h_nxt;
  logic        [15:0] s2_color_r, s2_color_nxt;
  logic               s2_last_r, s2_last_nxt;

  // Right and bottom clipping stage.
  logic               s3_valid_r, s3_valid_nxt;
  logic               s3_vis_r, s3_vis_nxt;
  logic        [10:0] s3_x_r, s3_x_nxt;
  logic        [10:0] s3_y_r, s3_y_nxt;
  logic        [3:0]  s3_w_r, s3_w_nxt;
  logic        [3:0]  s3_h_r, s3_h_nxt;
  logic        [15:0] s3_color_r, s3_color_nxt;
  logic               s3_last_r, s3_last_nxt;

  logic signed [12:0] s2_x_sum;
  logic signed [12:0] s2_y_sum;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic        out_vis_r, out_vis_nxt;
  logic [10:0] out_xs_r, out_xs_nxt;
  logic [10:0] out_xe_r, out_xe_nxt;
  logic [10:0] out_ys_r, out_ys_nxt;
  logic [10:0] out_ye_r, out_ye_nxt;
  logic [15:0] out_color_r, out_color_nxt;
  logic [7:0]  out_pix_r, out_pix_nxt;
  logic        out_last_r, out_last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= ScreenWidthRst;
      screen_height_r <= ScreenHeightRst;
      column_offset_r <= ColOffsetRst;
      row_offset_r    <= RowOffsetRst;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_SCREEN_WIDTH:  screen_width_r  <= cfg_data;
        CFG_SCREEN_HEIGHT: screen_height_r <= cfg_data;
        CFG_COLUMN_OFFSET: column_offset_r <= cfg_data[7:0];
        CFG_ROW_OFFSET:    row_offset_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign adv          = !out_valid_r || out_res.ready;
  assign seq_last     = (col_r == 3'(GlyphCols - 1)) && (row_r == 3'(GlyphRows - 1));
  assign in_req.ready = adv && (!active_r || seq_last);
  assign in_fire      = in_req.valid && in_req.ready;

  always_comb begin
    active_nxt = active_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    oy_nxt     = oy_r;
    idx_nxt    = idx_r;
    fg_nxt     = fg_r;
    bg_nxt     = bg_r;
    s_nxt      = s_r;
    if (in_fire) begin
      active_nxt = 1'b1;
      col_nxt    = 3'd0;
      row_nxt    = 3'd0;
      x_nxt      = 12'(in_req.origin_x);
      y_nxt      = 12'(in_req.origin_y);
      oy_nxt     = 12'(in_req.origin_y);
      idx_nxt    = glyph_index(in_req.char_code);
      fg_nxt     = in_req.fore_color;
      bg_nxt     = in_req.back_color;
      s_nxt      = in_req.dot_scale;
    end else if (adv && active_r) begin
      if (seq_last) begin
        active_nxt = 1'b0;
      end else if (row_r == 3'(GlyphRows - 1)) begin
        row_nxt = 3'd0;
        col_nxt = col_r + 3'd1;
        y_nxt   = oy_r;
        x_nxt   = x_r + $signed({8'd0, s_r});
      end else begin
        row_nxt = row_r + 3'd1;
        y_nxt   = y_r + $signed({8'd0, s_r});
      end
    end
  end

  always_comb begin
    s2_valid_nxt = active_r;
    s2_color_nxt = GLYPH_ROM[idx_r][col_r][row_r] ? fg_r : bg_r;
    s2_last_nxt  = seq_last;
    s2_vis0_nxt  = !(x_r >= $signed({2'b00, screen_width_r}) ||
                     y_r >= $signed({2'b00, screen_height_r}) || s_r == 4'd0);
    if (x_r < 0) begin
      s2_w_nxt = $signed({8'd0, s_r}) + x_r;
      s2_x_nxt = 11'd0;
    end else begin
      s2_w_nxt = $signed({8'd0, s_r});
      s2_x_nxt = x_r[10:0];
    end
    if (y_r < 0) begin
      s2_h_nxt = $signed({8'd0, s_r}) + y_r;
      s2_y_nxt = 11'd0;
    end else begin
      s2_h_nxt = $signed({8'd0, s_r});
      s2_y_nxt = y_r[10:0];
    end
  end

  assign s2_x_sum = $signed({2'b00, s2_x_r}) + 13'(s2_w_r);
  assign s2_y_sum = $signed({2'b00, s2_y_r}) + 13'(s2_h_r);

  always_comb begin
    s3_valid_nxt = s2_valid_r;
    s3_color_nxt = s2_color_r;
    s3_last_nxt  = s2_last_r;
    s3_x_nxt     = s2_x_r;
    s3_y_nxt     = s2_y_r;
    s3_vis_nxt   = s2_vis0_r && (s2_w_r > 0) && (s2_h_r > 0);
    if (s2_x_sum > $signed({3'b000, screen_width_r})) begin
      s3_w_nxt = 4'({1'b0, screen_width_r} - s2_x_r);
    end else begin
      s3_w_nxt = s2_w_r[3:0];
    end
    if (s2_y_sum > $signed({3'b000, screen_height_r})) begin
      s3_h_nxt = 4'({1'b0, screen_height_r} - s2_y_r);
    end else begin
      s3_h_nxt = s2_h_r[3:0];
    end
  end

  always_comb begin
    out_valid_nxt = s3_valid_r;
    out_color_nxt = s3_color_r;
    out_last_nxt  = s3_last_r;
    out_vis_nxt   = s3_vis_r;
    if (s3_vis_r) begin
      out_xs_nxt  = s3_x_r + {3'd0, column_offset_r};
      out_xe_nxt  = s3_x_r + {7'd0, s3_w_r} + {3'd0, column_offset_r} - 11'd1;
      out_ys_nxt  = s3_y_r + {3'd0, row_offset_r};
      out_ye_nxt  = s3_y_r + {7'd0, s3_h_r} + {3'd0, row_offset_r} - 11'd1;
      out_pix_nxt = {4'd0, s3_w_r} * {4'd0, s3_h_r};
    end else begin
      out_xs_nxt  = 11'd0;
      out_xe_nxt  = 11'd0;
      out_ys_nxt  = 11'd0;
      out_ye_nxt  = 11'd0;
      out_pix_nxt = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      col_r       <= 3'd0;
      row_r       <= 3'd0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      if (adv) begin
        s2_valid_r  <= s2_valid_nxt;
        s3_valid_r  <= s3_valid_nxt;
        out_valid_r <= out_valid_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    oy_r  <= oy_nxt;
    idx_r <= idx_nxt;
    fg_r  <= fg_nxt;
    bg_r  <= bg_nxt;
    s_r   <= s_nxt;
    if (adv) begin
      s2_vis0_r   <= s2_vis0_nxt;
      s2_x_r      <= s2_x_nxt;
      s2_y_r      <= s2_y_nxt;
      s2_w_r      <= s2_w_nxt;
      s2_h_r      <= s2_h_nxt;
      s2_color_r  <= s2_color_nxt;
      s2_last_r   <= s2_last_nxt;
      s3_vis_r    <= s3_vis_nxt;
      s3_x_r      <= s3_x_nxt;
      s3_y_r      <= s3_y_nxt;
      s3_w_r      <= s3_w_nxt;
      s3_h_r      <= s3_h_nxt;
      s3_color_r  <= s3_color_nxt;
      s3_last_r   <= s3_last_nxt;
      out_vis_r   <= out_vis_nxt;
      out_xs_r    <= out_xs_nxt;
      out_xe_r    <= out_xe_nxt;
      out_ys_r    <= out_ys_nxt;
      out_ye_r    <= out_ye_nxt;
      out_color_r <= out_color_nxt;
      out_pix_r   <= out_pix_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.visible     = out_vis_r;
  assign out_res.win_x_start = out_xs_r;
  assign out_res.win_x_end   = out_xe_r;
  assign out_res.win_y_start = out_ys_r;
  assign out_res.win_y_end   = out_ye_r;
  assign out_res.fill_color  = out_color_r;
  assign out_res.pixel_total = out_pix_r;
  assign out_res.last_cell   = out_last_r;

  // A newly accepted character always starts at its first cell.
  a_start_first_cell: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (active_r && col_r == 3'd0 && row_r == 3'd0))
    else $error("sequencer did not restart at the first cell");

  // The sequencer never leaves the 5 by 7 glyph grid.
  a_cell_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (col_r < 3'(GlyphCols) && row_r < 3'(GlyphRows)))
    else $error("cell position outside the glyph");

  // A hidden square carries no window and no pixels.
  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_vis_r) |->
      (out_pix_r == 8'd0 && out_xs_r == 11'd0 && out_ye_r == 11'd0))
    else $error("hidden square has a non-empty window");

  // A clipped square never holds more pixels than a full dot can.
  a_pix_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pix_r <= 8'd225))
    else $error("pixel count above the largest dot");

  // A stall holds every stage of the pipeline.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res.ready) |=> ($stable(s3_valid_r) && $stable(s2_valid_r) &&
                                        $stable(col_r) && $stable(row_r)))
    else $error("pipeline moved while the output was stalled");

endmodule
